[rtl/isc_pkg.sv]
// ----------------------------------------------------------------------------
// IPv4 subnet calculator package
// Shared types, constants and helper functions of the subnet calculator.
// ----------------------------------------------------------------------------
package isc_pkg;

  // Pipeline depth from input register to output register
  localparam int unsigned NumStages = 7;

  localparam logic [31:0] AllOnes = 32'hffff_ffff;
  localparam logic [31:0] Mask31  = 32'hffff_fffe;
  localparam logic [31:0] TopBit  = 32'h8000_0000;

  typedef enum logic [1:0] {
    ClassA    = 2'd0,
    ClassB    = 2'd1,
    ClassC    = 2'd2,
    ClassNone = 2'd3
  } net_class_e;

  typedef enum logic [7:0] {
    CfgCidrMode  = 8'd0,
    CfgNormalize = 8'd1
  } cfg_reg_e;

  // Shortest prefix that classful rules allow, by class
  localparam logic [5:0] MinPrefix [0:3] = '{6'd8, 6'd16, 6'd24, 6'd1};

  // Load enables and valid bits of the pipeline stages
  typedef struct packed {
    logic [NumStages-1:0] load;
    logic [NumStages-1:0] valid;
  } pipe_ctrl_t;

  // Partial right smear: remaining shifted word and the OR gathered so far
  typedef struct packed {
    logic [31:0] y;
    logic [31:0] r;
  } smear_t;

  // Payload carried down the pipeline
  typedef struct packed {
    logic [31:0] addr;
    logic [31:0] mask;
    logic [31:0] count;
    logic [31:0] index;
    logic [31:0] lsb;
    logic        pow2;
    logic        contig;
    logic        short_rng;
    logic [31:0] hi_base;
    net_class_e  cls;
    logic [5:0]  prefix;
    logic [4:0]  wsel;
    smear_t      sm;
    logic        valid;
    logic [31:0] lo;
    logic [31:0] hi;
    logic [31:0] smask;
    logic        split_ok;
    logic [31:0] delta;
    logic [31:0] prod;
    logic [31:0] saddr;
  } pipe_t;

  // Bit position of a one-hot word
  function automatic logic [4:0] onehot_index(input logic [31:0] v);
    logic [4:0] idx;
    idx = '0;
    for (int i = 0; i < 32; i++) begin
      if (v[i]) idx = idx | 5'(i);
    end
    return idx;
  endfunction

  // Class from the top octet
  function automatic net_class_e classify(input logic [31:0] addr);
    net_class_e c;
    priority if (addr[31:24] == 8'd0) c = ClassNone;
    else if (!addr[31])               c = ClassA;
    else if (addr[31:30] == 2'b10)    c = ClassB;
    else if (addr[31:29] == 3'b110)   c = ClassC;
    else                              c = ClassNone;
    return c;
  endfunction

  // One binary digit of a right smear: when en, OR in y shifted by 0 .. 2^b-1
  // and move y on by 2^b
  function automatic smear_t smear_step(input logic [31:0] y, input logic [31:0] r,
                                        input logic en, input logic [2:0] b);
    smear_t      res;
    logic [31:0] s;
    s = y;
    for (int j = 0; j < 4; j++) begin
      if (3'(j) < b) s = s | (s >> (1 << j));
    end
    res.r = en ? (r | s) : r;
    res.y = en ? (y >> (1 << b)) : y;
    return res;
  endfunction

endpackage

[rtl/isc_pipe_ctrl.sv]
// ----------------------------------------------------------------------------
// Pipeline flow control
// Valid bits and per-stage load enables; a stage loads when it is empty or
// when the stage after it moves, so bubbles fill while the output stalls.
// ----------------------------------------------------------------------------
module isc_pipe_ctrl (
  input  logic                  clk_i,
  input  logic                  rst_ni,
  input  logic                  in_valid_i,
  input  logic                  out_ready_i,
  output logic                  in_ready_o,
  output isc_pkg::pipe_ctrl_t   ctrl_o
);
  import isc_pkg::*;

  logic [NumStages-1:0] valid_q, valid_d;
  logic [NumStages-1:0] load;

  // Ready chain from the output back to the input
  always_comb begin
    logic rdy;
    rdy = out_ready_i;
    for (int k = NumStages - 1; k >= 0; k--) begin
      load[k] = !valid_q[k] || rdy;
      rdy     = load[k];
    end
  end

  // Advance valid bits with the data
  always_comb begin
    valid_d[0] = load[0] ? in_valid_i : valid_q[0];
    for (int k = 1; k < NumStages; k++) begin
      valid_d[k] = load[k] ? valid_q[k-1] : valid_q[k];
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= '0;
    end else begin
      valid_q <= valid_d;
    end
  end

  assign in_ready_o   = load[0];
  assign ctrl_o.load  = load;
  assign ctrl_o.valid = valid_q;

endmodule

[rtl/ipv4_subnet_calculator.sv]
// ----------------------------------------------------------------------------
// IPv4 subnet calculator
// Class, mask validity, prefix length, subnet split and host range of one
// address and mask per beat.
//
//   channel   dir  handshake                    payload
//   s_axis    in   s_axis_tvalid/s_axis_tready  address, mask, split count, index
//   m_axis    out  m_axis_tvalid/m_axis_tready  subnet results
//   cfg       in   cfg_valid_i/cfg_ready_o      register index, write data
//
// One beat per cycle while the output is not stalled; each beat passes seven
// register stages into the output register, a depth set by the split smear
// (three stages) and the 32x32 index multiply with its add.
// Reset clears the stage valid bits and sets both mode registers to one.
// An output stall holds the output register; earlier stages keep filling
// until every stage is full, then the input stalls. Config is always ready.
// ----------------------------------------------------------------------------
module ipv4_subnet_calculator (
  input  logic          clk_i,
  input  logic          rst_ni,
  // ip_address[31:0], net_mask[63:32], split_count[95:64], split_index[127:96]
  input  logic [127:0]  s_axis_tdata,
  input  logic          s_axis_tvalid,
  output logic          s_axis_tready,
  // subnet_address[31:0], net_class[33:32], mask_valid[34], prefix_length[40:35],
  // split_ok[41], split_mask[73:42], split_address[105:74], range_low[137:106],
  // range_high[169:138], zero pad[175:170]
  output logic [175:0]  m_axis_tdata,
  output logic          m_axis_tvalid,
  input  logic          m_axis_tready,
  input  logic          cfg_valid_i,
  output logic          cfg_ready_o,
  input  logic [7:0]    cfg_index_i,
  input  logic [31:0]   cfg_data_i
);
  import isc_pkg::*;

  logic       cidr_mode_q;
  logic       normalize_q;
  pipe_ctrl_t ctrl;
  pipe_t      stage_q [NumStages];
  pipe_t      stage_d [NumStages];
  pipe_t      res;

  // Mode registers
  assign cfg_ready_o = 1'b1;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cidr_mode_q <= 1'b1;
      normalize_q <= 1'b1;
    end else if (cfg_valid_i) begin
      unique case (cfg_index_i)
        CfgCidrMode:  cidr_mode_q <= cfg_data_i[0];
        CfgNormalize: normalize_q <= cfg_data_i[0];
        default: ;
      endcase
    end
  end

  isc_pipe_ctrl u_ctrl (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (s_axis_tvalid),
    .out_ready_i (m_axis_tready),
    .in_ready_o  (s_axis_tready),
    .ctrl_o      (ctrl)
  );

  // Stage 1: normalize, isolate lowest mask bit, power-of-two and contiguity checks
  always_comb begin
    logic [31:0] a, m, c, inv;
    a   = s_axis_tdata[31:0];
    m   = s_axis_tdata[63:32];
    c   = s_axis_tdata[95:64];
    inv = ~m;
    stage_d[0]           = '0;
    stage_d[0].addr      = normalize_q ? (a & m) : a;
    stage_d[0].mask      = m;
    stage_d[0].count     = c;
    stage_d[0].index     = s_axis_tdata[127:96];
    stage_d[0].lsb       = m & (inv + 32'd1);
    stage_d[0].pow2      = ((c & (c - 32'd1)) == 32'd0) && (c[31:1] != 31'd0);
    stage_d[0].contig    = (m != 32'd0) && ((inv & (inv + 32'd1)) == 32'd0);
    stage_d[0].short_rng = (m != AllOnes) && (m != Mask31);
    stage_d[0].hi_base   = stage_d[0].addr | inv;
  end

  // Stage 2: prefix, class, host range, split width and first smear digits
  always_comb begin
    logic [4:0] tz;
    smear_t     sm;
    stage_d[1] = stage_q[0];
    tz = onehot_index(stage_q[0].lsb);
    stage_d[1].prefix = (stage_q[0].lsb == 32'd0) ? 6'd0 : (6'd32 - {1'b0, tz});
    stage_d[1].cls    = classify(stage_q[0].addr);
    stage_d[1].lo     = stage_q[0].addr + {31'd0, stage_q[0].short_rng};
    stage_d[1].hi     = stage_q[0].hi_base - {31'd0, stage_q[0].short_rng};
    // smear width is one less than log2 of the count
    stage_d[1].wsel   = onehot_index(stage_q[0].count) - 5'd1;
    sm = smear_step((stage_q[0].mask >> 1) | TopBit, 32'd0, stage_d[1].wsel[0], 3'd0);
    stage_d[1].sm = smear_step(sm.y, sm.r, stage_d[1].wsel[1], 3'd1);
  end

  // Stage 3: middle smear digits, mask validity
  always_comb begin
    smear_t sm;
    stage_d[2] = stage_q[1];
    sm = smear_step(stage_q[1].sm.y, stage_q[1].sm.r, stage_q[1].wsel[2], 3'd2);
    stage_d[2].sm = smear_step(sm.y, sm.r, stage_q[1].wsel[3], 3'd3);
    stage_d[2].valid = stage_q[1].contig &&
                       (cidr_mode_q ||
                        ((stage_q[1].cls != ClassNone) &&
                         (stage_q[1].prefix >= MinPrefix[stage_q[1].cls])));
  end

  // Stage 4: last smear digit, split mask and failure check
  always_comb begin
    smear_t      sm;
    logic [31:0] acc_prev, acc_last, m0;
    logic        fail;
    stage_d[3] = stage_q[2];
    sm = smear_step(stage_q[2].sm.y, stage_q[2].sm.r, stage_q[2].wsel[4], 3'd4);
    stage_d[3].sm = sm;
    m0       = (stage_q[2].mask >> 1) | TopBit;
    // mask before the final doubling, then one more step
    acc_prev = stage_q[2].mask | sm.r;
    acc_last = acc_prev | ((stage_q[2].wsel == 5'd0) ? m0 : (sm.r >> 1));
    fail     = !stage_q[2].pow2 || (acc_prev == AllOnes);
    stage_d[3].split_ok = !fail;
    stage_d[3].smask    = fail ? 32'd0 : acc_last;
  end

  // Stage 5: split block size
  always_comb begin
    stage_d[4] = stage_q[3];
    stage_d[4].delta = ~stage_q[3].smask + 32'd1;
  end

  // Stage 6: index times block size, low word
  always_comb begin
    stage_d[5] = stage_q[4];
    stage_d[5].prod = stage_q[4].delta * stage_q[4].index;
  end

  // Stage 7: split subnet address
  always_comb begin
    stage_d[6] = stage_q[5];
    stage_d[6].saddr = stage_q[5].split_ok ? (stage_q[5].addr + stage_q[5].prod) : 32'd0;
  end

  // Stage registers load under flow control
  for (genvar k = 0; k < NumStages; k++) begin : g_stage
    always_ff @(posedge clk_i) begin
      if (ctrl.load[k]) stage_q[k] <= stage_d[k];
    end
  end

  // Drive the result beat
  assign res           = stage_q[NumStages-1];
  assign m_axis_tvalid = ctrl.valid[NumStages-1];
  assign m_axis_tdata  = {6'd0, res.hi, res.lo, res.saddr, res.smask, res.split_ok,
                          res.prefix, res.valid, res.cls, res.addr};

  // An accepted beat lands in the first stage
  a_accept_lands: assert property (@(posedge clk_i) disable iff (!rst_ni)
    s_axis_tvalid && s_axis_tready |=> ctrl.valid[0])
    else $error("accepted beat missing from first stage");

  // A failed split reports zero mask and address
  a_fail_zero: assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid && !res.split_ok |-> (res.smask == 32'd0) && (res.saddr == 32'd0))
    else $error("failed split with nonzero mask or address");

  // A successful split needs a power-of-two count and sets the top mask bit
  a_split_shape: assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid && res.split_ok |-> res.pow2 && res.smask[31])
    else $error("split succeeded with bad count or mask");

endmodule
